### rtl/subscriber_registration_table_top_assert.svh
// Assertion macros for the subscriber registration table.
`ifndef SUBSCRIBER_REGISTRATION_TABLE_TOP_ASSERT_SVH
`define SUBSCRIBER_REGISTRATION_TABLE_TOP_ASSERT_SVH

// A property that must hold on every clock edge outside reset.
`define SRT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A property that must hold on every clock edge, reset included.
`define SRT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// Types, command and status codes shared by the subscriber table modules.
// ----------------------------------------------------------------------------
package srt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int RETRY_CAP_S_DEF = 60;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_UPDATE = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_FLUSH  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_PAGE     = 2'd3
  } status_t;

  typedef enum logic {
    CFG_INTERVAL = 1'b0,
    CFG_ATTEMPTS = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_APPLY,
    BK_DONE
  } bk_state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  nat_code;
    logic [4:0]  centre_code;
    logic [15:0] subscriber_number;
    logic [10:0] channel_in;
    logic        card_in;
    logic        card_in_valid;
    logic        ext_in;
    logic        ext_in_valid;
    logic        is_busy;
    logic        page_failed;
    logic        ctrl_chan_busy;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        gone;
    logic [2:0]  out_nat;
    logic [4:0]  out_centre;
    logic [15:0] out_number;
    logic [10:0] channel_out;
    logic        card_out;
    logic        ext_out;
    logic        last;
  } out_item_t;

  // Queue status handed from the queue to the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### rtl/srt_queue.sv
// ----------------------------------------------------------------------------
// srt_queue
// Short command queue between the front and the back part.
// ----------------------------------------------------------------------------
module srt_queue
  import srt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  in_item_t push_data,
  input  logic     pop,
  output in_item_t pop_data,
  output q_stat_t  stat
);

  in_item_t mem_r [QUEUE_DEPTH];
  logic [$clog2(QUEUE_DEPTH)-1:0] wp_r, rp_r;
  logic [$clog2(QUEUE_DEPTH):0]   cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + {{$clog2(QUEUE_DEPTH){1'b0}}, push}
                     - {{$clog2(QUEUE_DEPTH){1'b0}}, pop};
    end
  end

  assign pop_data   = mem_r[rp_r];
  assign stat.full  = (cnt_r == ($clog2(QUEUE_DEPTH)+1)'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

### rtl/srt_front.sv
// ----------------------------------------------------------------------------
// srt_front
// Accepts commands, classifies them and pushes them into the queue.
// ----------------------------------------------------------------------------
module srt_front
  import srt_pkg::*;
(
  input  logic     start,
  input  in_item_t in_item,
  input  q_stat_t  stat,
  output logic     busy,
  output logic     push,
  output in_item_t push_data
);

  // A command with an out-of-use field pattern still runs; only the
  // fields that matter for its class are kept, the rest are cleared.
  always_comb begin
    push_data = in_item;
    if (in_item.command != CMD_UPDATE) begin
      push_data.channel_in    = '0;
      push_data.card_in_valid = 1'b0;
      push_data.ext_in_valid  = 1'b0;
      push_data.is_busy       = 1'b0;
      push_data.page_failed   = 1'b0;
    end
    if (in_item.command != CMD_TICK) push_data.ctrl_chan_busy = 1'b0;
  end

  assign busy = stat.full;
  assign push = start && !stat.full;

endmodule

### rtl/srt_back.sv
// ----------------------------------------------------------------------------
// srt_back
// Walks the slot table for one command at a time and emits its results.
// ----------------------------------------------------------------------------
module srt_back
  import srt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int RETRY_CAP_S = RETRY_CAP_S_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  q_stat_t     stat,
  input  in_item_t    cmd_item,
  output logic        pop,
  input  logic [15:0] interval,
  input  logic [7:0]  attempts,
  output logic        out_valid,
  output out_item_t   out_item,
  output logic        idle
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [15:0] CAP = (RETRY_CAP_S > 65535) ? 16'hFFFF : 16'(RETRY_CAP_S);

  logic [TABLE_DEPTH-1:0] used_r, reg_r, run_r;
  logic [23:0] key_r   [TABLE_DEPTH];
  logic [10:0] chan_r  [TABLE_DEPTH];
  logic        card_r  [TABLE_DEPTH];
  logic        ext_r   [TABLE_DEPTH];
  logic [15:0] left_r  [TABLE_DEPTH];
  logic [7:0]  retry_r [TABLE_DEPTH];

  bk_state_t state_r, state_nxt;
  in_item_t  cur_r;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          hit_r, hit_nxt, free_r, free_nxt;
  logic [IW-1:0] hidx_r, hidx_nxt, fidx_r, fidx_nxt;
  logic          ov_r, ov_nxt;
  out_item_t     oi_r, oi_nxt;

  logic [IW-1:0] ix;
  logic [23:0]   ckey;
  logic [15:0]   retime;

  assign ix     = idx_r[IW-1:0];
  assign ckey   = {cur_r.nat_code, cur_r.centre_code, cur_r.subscriber_number};
  assign retime = (interval > CAP) ? CAP : interval;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    hit_r  <= hit_nxt;
    free_r <= free_nxt;
    hidx_r <= hidx_nxt;
    fidx_r <= fidx_nxt;
    oi_r   <= oi_nxt;
    if (pop) cur_r <= cmd_item;
  end

  // Slot table updates: one slot per cycle in the walk, one in apply.
  always_ff @(posedge clk) begin
    logic [IW-1:0] s;
    logic [7:0]    rc;
    if (!rst_n) begin
      used_r <= '0;
      reg_r  <= '0;
      run_r  <= '0;
    end else if (state_r == BK_WALK && cur_r.command == CMD_FLUSH) begin
      used_r[ix] <= 1'b0;
      reg_r[ix]  <= 1'b0;
      run_r[ix]  <= 1'b0;
    end else if (state_r == BK_WALK && cur_r.command == CMD_TICK) begin
      if (used_r[ix] && run_r[ix]) begin
        if (left_r[ix] > 16'd1) begin
          left_r[ix] <= left_r[ix] - 16'd1;
        end else if (cur_r.ctrl_chan_busy) begin
          left_r[ix]  <= interval;
          retry_r[ix] <= '0;
        end else begin
          run_r[ix]  <= 1'b0;
          left_r[ix] <= '0;
        end
      end
    end else if (state_r == BK_APPLY && cur_r.command == CMD_UPDATE
                 && (hit_r || free_r)) begin
      s  = hit_r ? hidx_r : fidx_r;
      rc = hit_r ? retry_r[s] : 8'd0;
      if (!hit_r) begin
        used_r[s] <= 1'b1;
        key_r[s]  <= ckey;
        left_r[s] <= '0;
      end
      chan_r[s] <= (cur_r.channel_in != '0) ? cur_r.channel_in
                 : (hit_r ? chan_r[s] : 11'd0);
      card_r[s] <= cur_r.card_in_valid ? cur_r.card_in : (hit_r ? card_r[s] : 1'b0);
      ext_r[s]  <= cur_r.ext_in_valid ? cur_r.ext_in : (hit_r ? ext_r[s] : 1'b0);
      reg_r[s]  <= hit_r ? reg_r[s] : 1'b1;
      run_r[s]  <= hit_r ? run_r[s] : 1'b0;
      retry_r[s] <= rc;
      if (cur_r.is_busy) begin
        run_r[s] <= 1'b0;
      end else if (!cur_r.page_failed) begin
        run_r[s]   <= 1'b1;
        left_r[s]  <= interval;
        retry_r[s] <= '0;
        reg_r[s]   <= 1'b1;
      end else begin
        if (rc != 8'hFF) rc = rc + 8'd1;
        retry_r[s] <= rc;
        if (attempts != '0 && rc == attempts) begin
          reg_r[s] <= 1'b0;
        end else begin
          run_r[s]  <= 1'b1;
          left_r[s] <= retime;
        end
      end
    end
  end

  always_comb begin
    logic [IW-1:0] s;
    logic [7:0]    rc;
    logic          gn;
    state_nxt = state_r;
    idx_nxt   = idx_r;
    hit_nxt   = hit_r;
    free_nxt  = free_r;
    hidx_nxt  = hidx_r;
    fidx_nxt  = fidx_r;
    ov_nxt    = 1'b0;
    oi_nxt    = oi_r;
    pop       = 1'b0;
    s  = hit_r ? hidx_r : fidx_r;
    rc = hit_r ? retry_r[s] : 8'd0;
    gn = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!stat.empty) begin
          pop       = 1'b1;
          idx_nxt   = '0;
          hit_nxt   = 1'b0;
          free_nxt  = 1'b0;
          state_nxt = BK_WALK;
        end
      end
      BK_WALK: begin
        case (cur_r.command)
          CMD_UPDATE, CMD_FIND: begin
            if (used_r[ix] && key_r[ix] == ckey && !hit_r
                && (cur_r.command == CMD_UPDATE || reg_r[ix])) begin
              hit_nxt  = 1'b1;
              hidx_nxt = ix;
            end
            if (!used_r[ix] && !free_r) begin
              free_nxt = 1'b1;
              fidx_nxt = ix;
            end
          end
          CMD_TICK: begin
            if (used_r[ix] && run_r[ix] && left_r[ix] <= 16'd1
                && !cur_r.ctrl_chan_busy) begin
              ov_nxt = 1'b1;
              oi_nxt = '{status: ST_PAGE, gone: 1'b0, out_nat: key_r[ix][23:21],
                         out_centre: key_r[ix][20:16], out_number: key_r[ix][15:0],
                         channel_out: chan_r[ix], card_out: card_r[ix],
                         ext_out: ext_r[ix], last: 1'b0};
            end
          end
          default: ;
        endcase
        idx_nxt = idx_r + 1'b1;
        if (idx_r == CW'(TABLE_DEPTH - 1)) begin
          state_nxt = BK_APPLY;
        end
      end
      BK_APPLY: begin
        ov_nxt    = 1'b1;
        state_nxt = BK_DONE;
        oi_nxt    = '0;
        oi_nxt.last = 1'b1;
        case (cur_r.command)
          CMD_UPDATE: begin
            oi_nxt.out_nat    = cur_r.nat_code;
            oi_nxt.out_centre = cur_r.centre_code;
            oi_nxt.out_number = cur_r.subscriber_number;
            if (!hit_r && !free_r) begin
              oi_nxt.status = ST_FULL;
            end else begin
              if (!cur_r.is_busy && cur_r.page_failed) begin
                if (rc != 8'hFF) rc = rc + 8'd1;
                gn = (attempts != '0 && rc == attempts);
              end
              oi_nxt.status = ST_OK;
              oi_nxt.gone   = gn;
              oi_nxt.channel_out = (cur_r.channel_in != '0) ? cur_r.channel_in
                                 : (hit_r ? chan_r[s] : 11'd0);
              oi_nxt.card_out = cur_r.card_in_valid ? cur_r.card_in
                              : (hit_r && card_r[s]);
              oi_nxt.ext_out  = cur_r.ext_in_valid ? cur_r.ext_in
                              : (hit_r && ext_r[s]);
            end
          end
          CMD_FIND: begin
            oi_nxt.out_nat    = cur_r.nat_code;
            oi_nxt.out_centre = cur_r.centre_code;
            oi_nxt.out_number = cur_r.subscriber_number;
            if (hit_r) begin
              oi_nxt.channel_out = chan_r[hidx_r];
              oi_nxt.card_out    = card_r[hidx_r];
              oi_nxt.ext_out     = ext_r[hidx_r];
            end else begin
              oi_nxt.status = ST_NOTFOUND;
            end
          end
          default: ;
        endcase
      end
      BK_DONE: begin
        state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign out_valid = ov_r;
  assign out_item  = oi_r;
  assign idle      = (state_r == BK_IDLE) && stat.empty;

endmodule

### rtl/subscriber_registration_table_top.sv
// With the queue empty, a command's final result reaches the output ports after
// the pop, the one-slot-per-cycle walk over the table and the apply step.
// The back part takes one command at a time, through the idle, walk, apply and
// done steps; two waiting commands fill the queue and raise busy.
// Page requests of a tick come out during the walk, at most one per cycle.
// Reset (synchronous, rst_n low) empties the table and the queue and restores
// the interval to 240 s and the attempt limit to 3. Results cannot be stalled.
// ----------------------------------------------------------------------------
// subscriber_registration_table_top
// Fixed table of mobile subscribers with availability timers and paging.
// ----------------------------------------------------------------------------
`include "subscriber_registration_table_top_assert.svh"

module subscriber_registration_table_top
  import srt_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int RETRY_CAP_S = RETRY_CAP_S_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_valid,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  // Configuration registers. A write takes effect at once, so writes are
  // expected only while no transaction is in flight.
  logic [15:0] interval_r;
  logic [7:0]  attempts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= 16'd240;
      attempts_r <= 8'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INTERVAL: interval_r <= cfg_wdata;
        CFG_ATTEMPTS: attempts_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // The front part takes each transaction into the queue; the back part
  // drains it one command at a time.
  q_stat_t  qstat;
  logic     push, pop, idle;
  in_item_t push_data, pop_data;

  srt_front u_front (
    .start     (start),
    .in_item   (in_item),
    .stat      (qstat),
    .busy      (busy),
    .push      (push),
    .push_data (push_data)
  );

  srt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (qstat)
  );

  srt_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .RETRY_CAP_S (RETRY_CAP_S)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .stat      (qstat),
    .cmd_item  (pop_data),
    .pop       (pop),
    .interval  (interval_r),
    .attempts  (attempts_r),
    .out_valid (out_valid),
    .out_item  (out_item),
    .idle      (idle)
  );

  // The queue never pushes while full nor pops while empty.
  `SRT_ASSERT(a_no_overflow, !(push && qstat.full), "queue overflow")
  `SRT_ASSERT(a_no_underflow, !(pop && qstat.empty), "queue underflow")
  // A final result leaves the back part with nothing in flight right after.
  `SRT_ASSERT(a_last_then_quiet, (out_valid && out_item.last) |=> !out_valid,
              "result right after a final result")
  // An idle back part with an empty queue has no result on the ports.
  `SRT_ASSERT(a_idle_quiet, idle |-> !out_valid, "result while the back part is idle")

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Subscriber registration table testbench
// Drives update, find, tick and flush transactions through the command port,
// predicts every result with a local model of the table, and compares them
// field by field in arrival order. The check interval and the attempt limit
// are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  import srt_pkg::*;

  localparam int DEPTH = 16;
  localparam int RETRY_CAP = 60;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 3 * (DEPTH + 3);

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_valid;
  out_item_t   out_item;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;

  subscriber_registration_table_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // Local copy of the table contents and configuration.
  logic        tbl_used [DEPTH];
  logic [23:0] tbl_key [DEPTH];
  logic [10:0] tbl_chan [DEPTH];
  logic        tbl_card [DEPTH];
  logic        tbl_ext [DEPTH];
  logic        tbl_reg [DEPTH];
  logic        tbl_run [DEPTH];
  logic [15:0] tbl_left [DEPTH];
  logic [7:0]  tbl_retry [DEPTH];
  logic [15:0] interval_s;
  logic [7:0]  attempt_limit;

  in_item_t  pending_cmds[$];
  out_item_t expected_results[$];
  int        error_count = 0;
  int        accepted_count = 0;
  bit        hold_sender = 1'b0;

  function automatic out_item_t make_result(logic [1:0] st, logic gn, logic [23:0] key,
                                            logic [10:0] ch, logic cd, logic ex, logic lst);
    out_item_t r;
    r.status = st;
    r.gone = gn;
    r.out_nat = key[23:21];
    r.out_centre = key[20:16];
    r.out_number = key[15:0];
    r.channel_out = ch;
    r.card_out = cd;
    r.ext_out = ex;
    r.last = lst;
    return r;
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < DEPTH; i++) begin
      tbl_used[i] = 0; tbl_key[i] = 0; tbl_chan[i] = 0; tbl_card[i] = 0;
      tbl_ext[i] = 0; tbl_reg[i] = 0; tbl_run[i] = 0; tbl_left[i] = 0;
      tbl_retry[i] = 0;
    end
  endfunction

  // Works out the results of one accepted transaction and queues them.
  function automatic void predict_table(in_item_t it);
    logic [23:0] key;
    int hit;
    logic gn;
    key = {it.nat_code, it.centre_code, it.subscriber_number};
    hit = -1;
    gn = 0;
    case (it.command)
      CMD_UPDATE: begin
        for (int i = 0; i < DEPTH; i++)
          if (hit < 0 && tbl_used[i] && tbl_key[i] == key) hit = i;
        if (hit < 0) begin
          for (int i = 0; i < DEPTH; i++)
            if (hit < 0 && !tbl_used[i]) hit = i;
          if (hit < 0) begin
            expected_results.push_back(make_result(ST_FULL, 0, key, 0, 0, 0, 1));
            return;
          end
          tbl_used[hit] = 1; tbl_key[hit] = key; tbl_chan[hit] = 0;
          tbl_card[hit] = 0; tbl_ext[hit] = 0; tbl_reg[hit] = 1;
          tbl_run[hit] = 0; tbl_left[hit] = 0; tbl_retry[hit] = 0;
        end
        if (it.channel_in != 0) tbl_chan[hit] = it.channel_in;
        if (it.card_in_valid) tbl_card[hit] = it.card_in;
        if (it.ext_in_valid) tbl_ext[hit] = it.ext_in;
        if (it.is_busy) begin
          tbl_run[hit] = 0;
        end else if (!it.page_failed) begin
          tbl_run[hit] = 1; tbl_left[hit] = interval_s;
          tbl_retry[hit] = 0; tbl_reg[hit] = 1;
        end else begin
          if (tbl_retry[hit] != 8'hFF) tbl_retry[hit]++;
          if (attempt_limit != 0 && tbl_retry[hit] == attempt_limit) begin
            tbl_reg[hit] = 0;
            gn = 1;
          end else begin
            tbl_run[hit] = 1;
            tbl_left[hit] = (interval_s > RETRY_CAP) ? 16'(RETRY_CAP) : interval_s;
          end
        end
        expected_results.push_back(make_result(ST_OK, gn, key, tbl_chan[hit],
                                               tbl_card[hit], tbl_ext[hit], 1));
      end
      CMD_FIND: begin
        for (int i = 0; i < DEPTH; i++)
          if (hit < 0 && tbl_used[i] && tbl_reg[i] && tbl_key[i] == key) hit = i;
        if (hit < 0)
          expected_results.push_back(make_result(ST_NOTFOUND, 0, key, 0, 0, 0, 1));
        else
          expected_results.push_back(make_result(ST_OK, 0, key, tbl_chan[hit],
                                                 tbl_card[hit], tbl_ext[hit], 1));
      end
      CMD_TICK: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (tbl_used[i] && tbl_run[i]) begin
            if (tbl_left[i] > 1) begin
              tbl_left[i]--;
            end else begin
              tbl_run[i] = 0;
              tbl_left[i] = 0;
              if (it.ctrl_chan_busy) begin
                tbl_run[i] = 1; tbl_left[i] = interval_s; tbl_retry[i] = 0;
              end else begin
                expected_results.push_back(make_result(ST_PAGE, 0, tbl_key[i], tbl_chan[i],
                                                       tbl_card[i], tbl_ext[i], 0));
              end
            end
          end
        end
        expected_results.push_back(make_result(ST_OK, 0, 0, 0, 0, 0, 1));
      end
      default: begin
        clear_table();
        expected_results.push_back(make_result(ST_OK, 0, 0, 0, 0, 0, 1));
      end
    endcase
  endfunction

  // Keys come from a small pool so that updates, finds and the full table meet.
  function automatic in_item_t rand_cmd(int pool);
    in_item_t it;
    int k;
    int r;
    it = in_item_t'({$urandom, $urandom});
    k = $urandom_range(pool - 1);
    it.nat_code = 3'(k * 5);
    it.centre_code = 5'(k * 11);
    it.subscriber_number = 16'(k * 16'h1357 ^ (k << 12));
    if ($urandom_range(15) == 0) begin
      it.nat_code = 3'($urandom); it.centre_code = 5'($urandom);
      it.subscriber_number = 16'($urandom);
    end
    r = $urandom_range(99);
    if (r < 45) it.command = CMD_UPDATE;
    else if (r < 65) it.command = CMD_FIND;
    else if (r < 98) it.command = CMD_TICK;
    else it.command = CMD_FLUSH;
    if ($urandom_range(3) == 0) it.channel_in = 0;
    it.page_failed = ($urandom_range(2) == 0);
    it.is_busy = ($urandom_range(4) == 0);
    return it;
  endfunction

  function automatic in_item_t directed_cmd(cmd_t c, logic [23:0] key, logic [10:0] ch,
                                            logic [3:0] flags, logic bsy, logic fl,
                                            logic ccb);
    in_item_t it;
    it = '0;
    it.command = c;
    {it.nat_code, it.centre_code, it.subscriber_number} = key;
    it.channel_in = ch;
    {it.card_in, it.card_in_valid, it.ext_in, it.ext_in_valid} = flags;
    it.is_busy = bsy;
    it.page_failed = fl;
    it.ctrl_chan_busy = ccb;
    return it;
  endfunction

  // Driver: bursts of transactions separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      // The transaction in flight is accepted at this edge.
      predict_table(in_item);
      accepted_count++;
      if (pending_cmds.size() != 0 && !hold_sender && burst_left > 0) begin
        in_item <= pending_cmds.pop_front();
        burst_left--;
      end else begin
        start <= 1'b0;
        if (burst_left == 0) gap_left = $urandom_range(0, 30);
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_cmds.size() != 0 && !hold_sender) begin
        if (burst_left == 0) burst_left = $urandom_range(1, 12);
        in_item <= pending_cmds.pop_front();
        start <= 1'b1;
        burst_left--;
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      accepted_count++;
      if (expected_results.size() == 0) begin
        $error("unexpected result %p", out_item);
        error_count++;
      end else begin
        out_item_t exp_r;
        exp_r = expected_results.pop_front();
        if (out_item.status !== exp_r.status) begin
          $error("status expected %0d actual %0d", exp_r.status, out_item.status);
          error_count++;
        end
        if (out_item.gone !== exp_r.gone) begin
          $error("gone expected %0d actual %0d", exp_r.gone, out_item.gone);
          error_count++;
        end
        if (out_item.out_nat !== exp_r.out_nat) begin
          $error("out_nat expected %0d actual %0d", exp_r.out_nat, out_item.out_nat);
          error_count++;
        end
        if (out_item.out_centre !== exp_r.out_centre) begin
          $error("out_centre expected %0d actual %0d", exp_r.out_centre,
                 out_item.out_centre);
          error_count++;
        end
        if (out_item.out_number !== exp_r.out_number) begin
          $error("out_number expected %0d actual %0d", exp_r.out_number,
                 out_item.out_number);
          error_count++;
        end
        if (out_item.channel_out !== exp_r.channel_out) begin
          $error("channel_out expected %0d actual %0d", exp_r.channel_out,
                 out_item.channel_out);
          error_count++;
        end
        if (out_item.card_out !== exp_r.card_out) begin
          $error("card_out expected %0d actual %0d", exp_r.card_out, out_item.card_out);
          error_count++;
        end
        if (out_item.ext_out !== exp_r.ext_out) begin
          $error("ext_out expected %0d actual %0d", exp_r.ext_out, out_item.ext_out);
          error_count++;
        end
        if (out_item.last !== exp_r.last) begin
          $error("last expected %0d actual %0d", exp_r.last, out_item.last);
          error_count++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which no transaction of either kind moves.
  int idle_cycles = 0;
  int last_count = 0;
  always @(posedge clk) begin
    if (accepted_count != last_count) begin
      idle_cycles = 0;
      last_count = accepted_count;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Waits until the block is idle: nothing queued, nothing predicted.
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_INTERVAL) interval_s = val;
    else attempt_limit = val[7:0];
  endtask

  initial begin
    logic [23:0] k0;
    logic [23:0] k1;
    clear_table();
    interval_s = 16'd240;
    attempt_limit = 8'd3;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: short interval and a limit of two to reach expiry and gone.
    write_reg(CFG_INTERVAL, 16'd1);
    write_reg(CFG_ATTEMPTS, 8'd2);
    k0 = 24'hFFFFFF;
    k1 = 24'h000000;
    pending_cmds.push_back(directed_cmd(CMD_FIND, k0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(directed_cmd(CMD_UPDATE, k0, 11'h7FF, 4'b1111, 0, 0, 0));
    pending_cmds.push_back(directed_cmd(CMD_UPDATE, k1, 11'd1, 4'b0101, 0, 0, 0));
    pending_cmds.push_back(directed_cmd(CMD_UPDATE, k0, 0, 4'b0000, 0, 0, 0));
    pending_cmds.push_back(directed_cmd(CMD_FIND, k0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(directed_cmd(CMD_TICK, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(directed_cmd(CMD_UPDATE, k1, 0, 0, 0, 1, 0));
    pending_cmds.push_back(directed_cmd(CMD_TICK, 0, 0, 0, 0, 0, 1));
    // Busy and failed together: busy wins.
    pending_cmds.push_back(directed_cmd(CMD_UPDATE, k1, 0, 0, 1, 1, 0));
    pending_cmds.push_back(directed_cmd(CMD_UPDATE, k1, 0, 0, 0, 1, 0));
    pending_cmds.push_back(directed_cmd(CMD_FIND, k1, 0, 0, 0, 0, 0));
    // An entry with a failed page is updated again and found.
    pending_cmds.push_back(directed_cmd(CMD_UPDATE, k1, 11'd5, 4'b1010, 0, 0, 0));
    pending_cmds.push_back(directed_cmd(CMD_FIND, k1, 0, 0, 0, 0, 0));
    // Fill the table and overflow it.
    for (int i = 0; i < 15; i++)
      pending_cmds.push_back(directed_cmd(CMD_UPDATE, 24'h100000 + 24'(i), 0, 0, 0, 0, 0));
    pending_cmds.push_back(directed_cmd(CMD_UPDATE, 24'h0F0F0F, 0, 0, 0, 0, 0));
    pending_cmds.push_back(directed_cmd(CMD_TICK, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(directed_cmd(CMD_FLUSH, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(directed_cmd(CMD_FIND, k0, 0, 0, 0, 0, 0));
    wait_idle();

    // Zero interval and the largest values.
    write_reg(CFG_INTERVAL, 16'd0);
    write_reg(CFG_ATTEMPTS, 8'd255);
    pending_cmds.push_back(directed_cmd(CMD_UPDATE, k0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(directed_cmd(CMD_TICK, 0, 0, 0, 0, 0, 0));
    wait_idle();

    // Random phases over several settings, extremes included.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(CFG_INTERVAL, 16'd2); write_reg(CFG_ATTEMPTS, 8'd0); end
        1: begin write_reg(CFG_INTERVAL, 16'd65535); write_reg(CFG_ATTEMPTS, 8'd1); end
        2: begin write_reg(CFG_INTERVAL, 16'd61); write_reg(CFG_ATTEMPTS, 8'd3); end
        3: begin write_reg(CFG_INTERVAL, 16'd1); write_reg(CFG_ATTEMPTS, 8'd255); end
        4: begin write_reg(CFG_INTERVAL, 16'd3); write_reg(CFG_ATTEMPTS, 8'd4); end
        default: begin
          write_reg(CFG_INTERVAL, 16'($urandom_range(1, 6)));
          write_reg(CFG_ATTEMPTS, 8'($urandom_range(0, 5)));
        end
      endcase
      for (int n = 0; n < 42; n++)
        pending_cmds.push_back(rand_cmd(phase == 3 ? 24 : 10));
      if (phase == 2) begin
        // Hold the sender until every predicted result has arrived.
        while (pending_cmds.size() > 20) @(posedge clk);
        hold_sender = 1'b1;
        while (start || expected_results.size() != 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
